>>> src/btlpm_pkg.sv
// Shared types and constants for the binary trie longest prefix match engine.
// No dependencies; imported by every other file of the block.
`default_nettype none

package btlpm_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int PORT_BITS  = 16;
    localparam int ADDR_BITS  = 32;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int USED_W     = $clog2(NODE_COUNT + 1);
    localparam int LEVEL_W    = $clog2(ADDR_BITS + 1);
    localparam int PLEN_W     = 6;
    localparam int OUT_PORT_W = 16;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_OUT
    } t_state;

    // One trie node as stored
    typedef struct packed {
        logic [NODE_W-1:0]    zero_child;
        logic [NODE_W-1:0]    one_child;
        logic                 has_port;
        logic [PORT_BITS-1:0] port;
    } t_node_word;

    // Node write request from the sequencer to the node store
    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] node;
        t_node_word        word;
    } t_node_wr;

endpackage

`default_nettype wire

>>> src/binary_trie_longest_prefix_match.sv
// IPv4 longest prefix match on a one-bit-per-level binary trie.
// Flow: accept in S_IDLE, walk the trie in S_WALK (root down to at most level 32), then hold the
// result in S_OUT; the next item is taken only once the result is transferred.
// Rate is set by the node store read port: one node read per address bit.
// Reset (sync, active low): root empty, nodes_used = 1, FSM idle; no memory clear pass.
// Depends on btlpm_pkg and btlpm_node_store.
`default_nettype none

module binary_trie_longest_prefix_match
    import btlpm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request channel
    input  wire logic                  i_valid,
    output      logic                  o_stall,
    input  wire logic                  i_op,
    input  wire logic [ADDR_BITS-1:0]  i_address,
    input  wire logic [PLEN_W-1:0]     i_prefix_length,
    input  wire logic [15:0]           i_port_value,
    // result channel
    output      logic                  o_valid,
    input  wire logic                  i_stall,
    output      logic                  o_found,
    output      logic [OUT_PORT_W-1:0] o_port_out,
    output      logic                  o_pool_full
);

    t_state r_state, n_state;

    // per-item work registers
    t_op                  r_op,       n_op;
    logic [ADDR_BITS-1:0] r_addr,     n_addr;     // shifted left, MSB is the current bit
    logic [LEVEL_W-1:0]   r_level,    n_level;
    logic [LEVEL_W-1:0]   r_plen,     n_plen;
    logic [PORT_BITS-1:0] r_port,     n_port;
    logic [NODE_W-1:0]    r_node,     n_node;
    logic                 r_fresh,    n_fresh;    // current node newly allocated, reads as empty
    logic                 r_hit,      n_hit;
    logic [PORT_BITS-1:0] r_best,     n_best;
    logic [USED_W-1:0]    r_used,     n_used;

    // result registers
    logic                  r_found,     n_found;
    logic [OUT_PORT_W-1:0] r_port_out,  n_port_out;
    logic                  r_pool_full, n_pool_full;

    logic              in_xfer;
    logic              out_xfer;
    logic              walk_done;
    t_node_word        rd_word;
    t_node_word        cur_word;
    t_node_word        wr_word;
    t_node_wr          node_wr;
    logic [NODE_W-1:0] child;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = o_valid && !i_stall;

    btlpm_node_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (node_wr),
        .i_rd_node (n_node),
        .o_rd_word (rd_word)
    );

    // Current node contents: a fresh node has no children and no port.
    assign cur_word = r_fresh ? t_node_word'('0) : rd_word;
    assign child    = r_addr[ADDR_BITS-1] ? cur_word.one_child : cur_word.zero_child;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = S_WALK;
            end
            S_WALK: begin
                if (walk_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- handshake outputs ----------------
    always_comb begin
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE:  o_stall = 1'b0;
            S_WALK:  o_stall = 1'b1;
            S_OUT:   o_valid = 1'b1;
            default: o_stall = 1'b1;
        endcase
    end

    // ---------------- walk datapath ----------------
    // One trie level per cycle. Inserts write each touched node once, with its
    // final contents: a parent link when a child is allocated, the port at the
    // end, or a cleared fresh node when the pool runs dry.
    always_comb begin
        n_op        = r_op;
        n_addr      = r_addr;
        n_level     = r_level;
        n_plen      = r_plen;
        n_port      = r_port;
        n_node      = r_node;
        n_fresh     = r_fresh;
        n_hit       = r_hit;
        n_best      = r_best;
        n_used      = r_used;
        n_found     = r_found;
        n_port_out  = r_port_out;
        n_pool_full = r_pool_full;
        walk_done   = 1'b0;
        wr_word     = cur_word;
        node_wr     = '0;

        if (r_state == S_IDLE && in_xfer) begin
            n_op    = t_op'(i_op);
            n_addr  = i_address;
            n_level = '0;
            n_plen  = (i_prefix_length > PLEN_W'(ADDR_BITS)) ? LEVEL_W'(ADDR_BITS)
                                                            : LEVEL_W'(i_prefix_length);
            n_port  = i_port_value[PORT_BITS-1:0];
            n_node  = '0;
            n_fresh = 1'b0;
            n_hit   = 1'b0;
            n_best  = '0;
        end else if (r_state == S_WALK) begin
            if (r_op == OP_LOOKUP) begin
                if (cur_word.has_port) begin
                    n_hit  = 1'b1;
                    n_best = cur_word.port;
                end
                if (r_level == LEVEL_W'(ADDR_BITS) || child == '0) begin
                    walk_done   = 1'b1;
                    n_found     = r_hit || cur_word.has_port;
                    n_port_out  = OUT_PORT_W'(cur_word.has_port ? cur_word.port : r_best);
                    n_pool_full = 1'b0;
                end else begin
                    n_node  = child;
                    n_level = r_level + LEVEL_W'(1);
                    n_addr  = r_addr << 1;
                end
            end else begin
                if (r_level == r_plen) begin
                    // final node takes the route, overwriting any earlier port
                    wr_word.has_port = 1'b1;
                    wr_word.port     = r_port;
                    node_wr.en       = 1'b1;
                    walk_done        = 1'b1;
                    n_found          = 1'b0;
                    n_port_out       = '0;
                    n_pool_full      = 1'b0;
                end else if (child != '0) begin
                    n_node  = child;
                    n_level = r_level + LEVEL_W'(1);
                    n_addr  = r_addr << 1;
                end else if (r_used == USED_W'(NODE_COUNT)) begin
                    // pool exhausted: a fresh node still needs its cleared word
                    node_wr.en  = r_fresh;
                    walk_done   = 1'b1;
                    n_found     = 1'b0;
                    n_port_out  = '0;
                    n_pool_full = 1'b1;
                end else begin
                    if (r_addr[ADDR_BITS-1]) begin
                        wr_word.one_child  = r_used[NODE_W-1:0];
                    end else begin
                        wr_word.zero_child = r_used[NODE_W-1:0];
                    end
                    node_wr.en = 1'b1;
                    n_node     = r_used[NODE_W-1:0];
                    n_used     = r_used + USED_W'(1);
                    n_fresh    = 1'b1;
                    n_level    = r_level + LEVEL_W'(1);
                    n_addr     = r_addr << 1;
                end
            end
        end
        node_wr.node = r_node;
        node_wr.word = wr_word;
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= USED_W'(1);
            r_node  <= '0;
            r_fresh <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_node  <= n_node;
            r_fresh <= n_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_addr      <= n_addr;
        r_level     <= n_level;
        r_plen      <= n_plen;
        r_port      <= n_port;
        r_hit       <= n_hit;
        r_best      <= n_best;
        r_found     <= n_found;
        r_port_out  <= n_port_out;
        r_pool_full <= n_pool_full;
    end

    assign o_found     = r_found;
    assign o_port_out  = r_port_out;
    assign o_pool_full = r_pool_full;

    // ---------------- assertions ----------------
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(NODE_COUNT) && r_used != '0)
        else $error("node count out of range");

    a_wr_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        node_wr.en |-> r_state == S_WALK && r_op == OP_INSERT)
        else $error("node write outside an insert walk");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_op == OP_INSERT) |-> r_level <= r_plen)
        else $error("insert walked past the prefix length");

    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && n_fresh && !r_fresh) |-> n_used == r_used + USED_W'(1))
        else $error("fresh node without allocation");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_found && o_pool_full))
        else $error("result flags both set");

endmodule

`default_nettype wire

>>> src/btlpm_node_store.sv
// Node pool: root node in flops, all other nodes in a single-port-write memory.
// Depends on btlpm_pkg. Read data is registered; node 0 reads the root flops.
`default_nettype none

module btlpm_node_store
    import btlpm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_node_wr          i_wr,
    input  wire logic [NODE_W-1:0] i_rd_node,
    output      t_node_word        o_rd_word
);

    t_node_word        r_mem [NODE_COUNT];
    t_node_word        r_mem_q;
    t_node_word        r_root;
    logic [NODE_W-1:0] r_rd_node;

    // root starts empty; the rest is cleared on allocation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (i_wr.en && i_wr.node == '0) begin
            r_root <= i_wr.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.node != '0) begin
            r_mem[i_wr.node] <= i_wr.word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mem_q   <= r_mem[i_rd_node];
        r_rd_node <= i_rd_node;
    end

    assign o_rd_word = (r_rd_node == '0) ? r_root : r_mem_q;

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for binary_trie_longest_prefix_match (IPv4 LPM on a binary trie).
// Holds its own trie predictor in a scoreboard class; random traffic with bursty valid
// and a patterned stall. Depends on btlpm_pkg and the block's RTL only.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import btlpm_pkg::*;

    // Run limit: leaves a wide margin over the whole run while still catching
    // a hung handshake.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;   // margin after the last answer
    localparam int RANDOM_ITEMS = 380;
    localparam int REPORT_MAX   = 10;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_RUNS
    } t_stall_mode;

    // One expected answer from the block
    typedef struct packed {
        logic                  found;
        logic [OUT_PORT_W-1:0] port;
        logic                  pool_full;
    } t_answer;

    // A route as stored, length already clipped to 32
    typedef struct {
        logic [ADDR_BITS-1:0] addr;
        int unsigned          len;
    } t_route;

    // ------------------------------------------------------------------
    // Scoreboard: private copy of the trie, walked once per accepted
    // request, plus the queue of answers still owed by the block.
    // ------------------------------------------------------------------
    class lpm_scoreboard;
        int unsigned          zero_kid [NODE_COUNT];
        int unsigned          one_kid  [NODE_COUNT];
        bit                   has_port [NODE_COUNT];
        logic [PORT_BITS-1:0] stored_port [NODE_COUNT];
        int unsigned          nodes_used;
        t_answer              answer_q [$];
        int                   mismatches;

        function new();
            zero_kid[0] = 0;
            one_kid[0]  = 0;
            has_port[0] = 1'b0;
            nodes_used  = 1;
            mismatches  = 0;
        endfunction

        function void note_request(t_op op, logic [ADDR_BITS-1:0] addr,
                                   logic [PLEN_W-1:0] plen, logic [15:0] port_val);
            t_answer     ans;
            int unsigned node;
            int unsigned child;
            int unsigned depth;
            int unsigned lvl;
            logic        dir;
            ans  = '0;
            node = 0;
            if (op == OP_INSERT) begin
                depth = (plen > 32) ? 32 : plen;
                for (lvl = 0; lvl < depth; lvl++) begin
                    dir   = addr[31 - lvl];
                    child = dir ? one_kid[node] : zero_kid[node];
                    if (child == 0) begin
                        // out of nodes: partial path stays, no port written
                        if (nodes_used >= NODE_COUNT) begin
                            ans.pool_full = 1'b1;
                            break;
                        end
                        child = nodes_used;
                        nodes_used++;
                        zero_kid[child] = 0;
                        one_kid[child]  = 0;
                        has_port[child] = 1'b0;
                        stored_port[child] = '0;
                        if (dir) one_kid[node] = child;
                        else zero_kid[node] = child;
                    end
                    node = child;
                end
                if (!ans.pool_full) begin
                    has_port[node]    = 1'b1;
                    stored_port[node] = port_val[PORT_BITS-1:0];
                end
            end else begin
                // deepest node with a port wins, root and /32 leaf included
                for (lvl = 0; lvl <= 32; lvl++) begin
                    if (has_port[node]) begin
                        ans.found = 1'b1;
                        ans.port  = OUT_PORT_W'(stored_port[node]);
                    end
                    if (lvl == 32) break;
                    node = addr[31 - lvl] ? one_kid[node] : zero_kid[node];
                    if (node == 0) break;
                end
            end
            answer_q.push_back(ans);
        endfunction

        function void check_answer(logic found, logic [OUT_PORT_W-1:0] port, logic pool_full);
            t_answer want;
            if (answer_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result with none expected: found=%0b port=%h pool_full=%0b",
                             $realtime, found, port, pool_full);
                return;
            end
            want = answer_q.pop_front();
            if (found !== want.found || port !== want.port || pool_full !== want.pool_full) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: mismatch: expected found=%0b port=%h pool_full=%0b, got found=%0b port=%h pool_full=%0b",
                             $realtime, want.found, want.port, want.pool_full,
                             found, port, pool_full);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_valid         = 1'b0;
    logic                  i_op            = 1'b0;
    logic [ADDR_BITS-1:0]  i_address       = '0;
    logic [PLEN_W-1:0]     i_prefix_length = '0;
    logic [15:0]           i_port_value    = '0;
    logic                  i_stall         = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic                  o_found;
    logic [OUT_PORT_W-1:0] o_port_out;
    logic                  o_pool_full;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    binary_trie_longest_prefix_match DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_address       (i_address),
        .i_prefix_length (i_prefix_length),
        .i_port_value    (i_port_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_found         (o_found),
        .o_port_out      (o_port_out),
        .o_pool_full     (o_pool_full)
    );

    lpm_scoreboard sb = new();
    t_route        routes [$];     // inserted routes, used to aim lookups at the trie
    int            burst_left = 0; // transfers left before the next idle gap
    int            cycle_count = 0;

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: stall pattern periodically picks a random mode among
    // no stall, coin-flip stall, and repeating runs of stalled cycles.
    // ------------------------------------------------------------------
    t_stall_mode stall_mode  = STALL_NONE;
    int          stall_phase = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall     <= 1'b0;
            stall_mode  <= STALL_NONE;
            stall_phase <= 0;
        end else begin
            if (stall_phase == 0) begin
                stall_mode  <= t_stall_mode'($urandom_range(2));
                stall_phase <= 63;
            end else begin
                stall_phase <= stall_phase - 1;
            end
            case (stall_mode)
                STALL_NONE:   i_stall <= 1'b0;
                STALL_RANDOM: i_stall <= 1'($urandom_range(1));
                default:      i_stall <= ((stall_phase % 16) >= 6);
            endcase
        end
    end

    // Values sampled here are the pre-edge ones, so the check sees exactly
    // what the block presented at the transfer edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_answer(o_found, o_port_out, o_pool_full);
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Present one request, hold it until transferred, then maybe idle.
    // Valid stays high across back-to-back transfers (no low/high in one step).
    task automatic send_request(t_op op, logic [ADDR_BITS-1:0] addr,
                                logic [PLEN_W-1:0] plen, logic [15:0] port_val);
        int idle_len;
        i_valid         <= 1'b1;
        i_op            <= op;
        i_address       <= addr;
        i_prefix_length <= plen;
        i_port_value    <= port_val;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(op, addr, plen, port_val);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            idle_len = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (idle_len) @(posedge i_clk);
            // mostly short bursts, now and then a long gap-free stretch
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
        end
    endtask

    task automatic insert_route(logic [ADDR_BITS-1:0] addr, logic [PLEN_W-1:0] plen,
                                logic [15:0] port_val);
        t_route r;
        r.addr = addr;
        r.len  = (plen > 32) ? 32 : plen;
        routes.push_back(r);
        send_request(OP_INSERT, addr, plen, port_val);
    endtask

    // Prefix length and port are don't-care on a lookup; drive noise there.
    task automatic lookup_address(logic [ADDR_BITS-1:0] addr);
        send_request(OP_LOOKUP, addr, PLEN_W'($urandom_range(63)), 16'($urandom()));
    endtask

    initial begin
        t_route               r;
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] keep;
        logic [PLEN_W-1:0]    plen;
        int                   pick;
        int                   flip;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(0, 8);

        // --- directed part ---
        lookup_address(32'h0000_0000);                 // empty trie misses
        lookup_address(32'hFFFF_FFFF);
        insert_route(32'h0000_0000, 6'd0, 16'h1234);   // /0 route lives on the root
        lookup_address(32'h1234_5678);
        insert_route(32'hFFFF_FFFF, 6'd32, 16'hFFFF);  // full-depth leaf
        lookup_address(32'hFFFF_FFFF);
        lookup_address(32'hFFFF_FFFE);                 // one bit off: falls back to /0
        insert_route(32'h0000_0000, 6'd32, 16'h0000);  // hit with port zero
        lookup_address(32'h0000_0000);
        insert_route(32'h0A00_0000, 6'd8, 16'h000A);
        insert_route(32'h0A0B_0000, 6'd16, 16'h5555);
        lookup_address(32'h0A0B_0C0D);                 // longest is the /16
        lookup_address(32'h0A0C_0000);                 // the /8 is the longest match
        insert_route(32'h0A00_0000, 6'd8, 16'hAAAA);   // overwrite an existing route
        lookup_address(32'h0A0C_0000);
        insert_route(32'h8000_0001, 6'd63, 16'hABCD);  // over-long length clips to 32
        lookup_address(32'h8000_0001);
        lookup_address(32'h8000_0000);                 // path exists, no port below root
        insert_route(32'hC0A8_0000, 6'd33, 16'h00FF);
        lookup_address(32'hC0A8_0000);
        insert_route(32'h7FFF_FFFF, 6'd1, 16'h8001);   // /1 sits above the 0/32 leaf path
        lookup_address(32'h0000_0001);

        // --- random part: lookups mostly aimed at stored routes ---
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(99) < 35) begin
                pick = $urandom_range(99);
                if (pick < 40)      plen = PLEN_W'($urandom_range(0, 12));
                else if (pick < 75) plen = PLEN_W'($urandom_range(13, 24));
                else if (pick < 95) plen = PLEN_W'($urandom_range(25, 32));
                else                plen = PLEN_W'($urandom_range(33, 63));
                // half of them branch off an existing route to share upper nodes
                if ($urandom_range(1) == 1) begin
                    r    = routes[$urandom_range(routes.size() - 1)];
                    addr = r.addr ^ ($urandom() >> $urandom_range(0, 31));
                end else begin
                    addr = $urandom();
                end
                insert_route(addr, plen, 16'($urandom()));
            end else if ($urandom_range(9) < 7) begin
                r    = routes[$urandom_range(routes.size() - 1)];
                keep = (r.len == 0) ? '0 : ({ADDR_BITS{1'b1}} << (32 - r.len));
                addr = (r.addr & keep) | ($urandom() & ~keep);
                // sometimes break the match inside the prefix
                if (r.len > 0 && $urandom_range(4) == 0) begin
                    flip = 32 - $urandom_range(1, r.len);
                    addr[flip] = ~addr[flip];
                end
                lookup_address(addr);
            end else begin
                lookup_address($urandom());
            end
        end

        // --- fill the node pool, then push past it ---
        while (sb.nodes_used < NODE_COUNT)
            insert_route($urandom(), 6'd32, 16'($urandom()));
        for (int n = 0; n < 10; n++) begin
            insert_route($urandom(), 6'd32, 16'($urandom()));
            r = routes[$urandom_range(routes.size() - 1)];
            lookup_address(r.addr);
        end

        // --- drain ---
        i_valid <= 1'b0;
        while (sb.answer_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
